>>> hdl/dwpi_pkg.sv
// shared types, constants and helpers for the dual wheel pi speed drive
`default_nettype none
package dwpi_pkg;

   localparam int SPEED_W  = 16;   // signed Q11.4 speeds and targets
   localparam int GAIN_W   = 16;   // unsigned Q8.8 gains
   localparam int ERR_W    = 11;   // clamped error, +-800 in Q.4
   localparam int PROD_W   = 28;   // gain * error
   localparam int INC_W    = PROD_W - 8;
   localparam int INTEG_W  = 15;   // integral, +-9600 in Q.4
   localparam int SUM_W    = 21;
   localparam int DRIVE_W  = 17;   // drive, holds up to +-65535
   localparam int DEBUG_W  = 12;
   localparam int CMP_W    = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic signed [ERR_W-1:0]   ERR_LIMIT   = 11'sd800;
   localparam logic signed [SUM_W-1:0]   INTEG_LIMIT = 21'sd9600;
   localparam logic        [CMP_W-1:0]   BRAKE_LEVEL = 10'd1000;

   localparam logic [1:0] MODE_DEBUG = 2'd0;
   localparam logic [1:0] MODE_SPEED = 2'd1;
   localparam logic [1:0] MODE_ZERO  = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CTRL_MODE    = 3'd0,
      CSR_PROP_GAIN    = 3'd1,
      CSR_INTEG_GAIN   = 3'd2,
      CSR_LEFT_TARGET  = 3'd3,
      CSR_RIGHT_TARGET = 3'd4,
      CSR_DEBUG_DRIVE  = 3'd5,
      CSR_LEFT_DIR     = 3'd6,
      CSR_RIGHT_DIR    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
   } pi_gain_type;

   typedef struct packed {
      logic [CMP_W-1:0] cmp_a;
      logic [CMP_W-1:0] cmp_b;
   } bridge_cmp_type;

   function automatic logic signed [DRIVE_W-1:0] clamp_drive(
      input logic signed [DRIVE_W-1:0] x,
      input logic signed [DRIVE_W-1:0] lim
   );
      logic signed [DRIVE_W-1:0] r;
      if (x > lim) begin
         r = lim;
      end else if (x < -lim) begin
         r = -lim;
      end else begin
         r = x;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/dwpi_pi_loop.sv
// one wheel pi loop: error clamp, clamped integral, clamped drive
`default_nettype none
module dwpi_pi_loop
   import dwpi_pkg::*;
#(
   parameter int DRIVE_LIMIT = 999
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        update,
   input  wire pi_gain_type                 gains,
   input  wire logic signed [SPEED_W-1:0]   target,
   input  wire logic signed [SPEED_W-1:0]   meas,
   output      logic signed [DRIVE_W-1:0]   drive
);

   localparam logic signed [DRIVE_W-1:0] LIMIT = DRIVE_W'(DRIVE_LIMIT);

   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;

   logic signed [SPEED_W:0]   err_raw;
   logic signed [ERR_W-1:0]   err;
   logic signed [PROD_W-1:0]  prod_i, prod_p;
   logic signed [SUM_W-1:0]   acc_sum, acc_clamped, out_sum, out_adj;
   logic signed [DRIVE_W-1:0] quot;

   always_comb begin
      err_raw = {target[SPEED_W-1], target} - {meas[SPEED_W-1], meas};
      if (err_raw > (SPEED_W+1)'(ERR_LIMIT)) begin
         err = ERR_LIMIT;
      end else if (err_raw < -(SPEED_W+1)'(ERR_LIMIT)) begin
         err = -ERR_LIMIT;
      end else begin
         err = err_raw[ERR_W-1:0];
      end

      prod_i = PROD_W'($signed({1'b0, gains.integ})) * PROD_W'(err);
      prod_p = PROD_W'($signed({1'b0, gains.prop})) * PROD_W'(err);

      // dropping 8 low bits floors toward minus infinity
      acc_sum = SUM_W'(integ_ff) + SUM_W'($signed(prod_i[PROD_W-1:8]));
      if (acc_sum > INTEG_LIMIT) begin
         acc_clamped = INTEG_LIMIT;
      end else if (acc_sum < -INTEG_LIMIT) begin
         acc_clamped = -INTEG_LIMIT;
      end else begin
         acc_clamped = acc_sum;
      end
      integ_in = acc_clamped[INTEG_W-1:0];

      out_sum = acc_clamped + SUM_W'($signed(prod_p[PROD_W-1:8]));
      // divide by 16 toward zero
      out_adj = out_sum + (out_sum[SUM_W-1] ? SUM_W'(15) : SUM_W'(0));
      quot    = out_adj[SUM_W-1:4];
      drive_in = clamp_drive(quot, LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         drive_ff <= '0;
      end else if (update) begin
         integ_ff <= integ_in;
         drive_ff <= drive_in;
      end
   end

   // a fresh update is shown on the same tick
   assign drive = update ? drive_in : drive_ff;

endmodule
`default_nettype wire

>>> hdl/dwpi_bridge_map.sv
// maps a signed wheel drive and polarity onto two h-bridge compare values
`default_nettype none
module dwpi_bridge_map
   import dwpi_pkg::*;
(
   input  wire logic signed [DRIVE_W-1:0] drive,
   input  wire logic                      pos_on_a,
   output      bridge_cmp_type            cmp
);

   logic [DRIVE_W-1:0] mag;
   logic               on_a;

   always_comb begin
      mag  = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
      on_a = drive[DRIVE_W-1] ? !pos_on_a : pos_on_a;
      cmp.cmp_a = on_a ? mag[CMP_W-1:0] : '0;
      cmp.cmp_b = on_a ? '0 : mag[CMP_W-1:0];
   end

endmodule
`default_nettype wire

>>> hdl/dual_wheel_pi_speed_hbridge_drive.sv
// top level of the dual wheel pi speed controller with h-bridge compare outputs
`default_nettype none
// Each req word is one control tick: measured left and right wheel speeds
// (signed Q11.4) and a lock flag. Each tick gives exactly one rsp word with
// four h-bridge compare values and a braking flag. In speed mode (ctrl_mode 1)
// every TICK_DIVIDE-th tick runs both pi loops, and the new drives go out on
// that same tick; debug mode drives both wheels with debug_drive clamped to
// +-DRIVE_LIMIT, other modes drive zero. A locked tick forces all four
// compare values to 1000 and sets braking, while the pi loops still update.
// Throughput is one word per clock while rsp_tready is high: a word sits in
// the input register, the whole pi update and bridge mapping settle into
// the result register, which drives rsp_tvalid. The input register keeps
// taking words while a result waits as long as the result register drains
// on the same edge. Configuration is to be written by the user through the
// csr port only while no tick is in flight; the block does not enforce it.
module dual_wheel_pi_speed_hbridge_drive
   import dwpi_pkg::*;
#(
   parameter int TICK_DIVIDE = 2,
   parameter int DRIVE_LIMIT = 999
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tick input
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [31:0]           req_tdata,   // left_speed, right_speed
   input  wire logic                  req_tuser,   // locked
   // result output
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [39:0]           rsp_tdata,   // right_cmp_a, right_cmp_b,
                                                   // left_cmp_a, left_cmp_b
   output      logic                  rsp_tuser,   // braking
   // register writes
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PHASE_W = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TICK_DIVIDE - 1);
   localparam logic signed [DRIVE_W-1:0] LIMIT = DRIVE_W'(DRIVE_LIMIT);

   // configuration registers
   logic [1:0]                 mode_ff;
   pi_gain_type                gains_ff;
   logic signed [SPEED_W-1:0]  left_target_ff, right_target_ff;
   logic signed [DEBUG_W-1:0]  debug_drive_ff;
   logic                       left_dir_ff, right_dir_ff;

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic signed [SPEED_W-1:0]  in_left_ff, in_right_ff;
   logic                       in_lock_ff;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [39:0]                rsp_data_ff;
   logic                       rsp_brake_ff;

   logic [PHASE_W-1:0]         phase_ff, phase_in;

   logic                       advance, speed_tick, pi_update;
   logic signed [DRIVE_W-1:0]  left_pi, right_pi, left_drv, right_drv, dbg_drv;
   bridge_cmp_type             left_cmp, right_cmp;
   logic [39:0]                data_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_SPEED;
         gains_ff        <= '0;
         left_target_ff  <= '0;
         right_target_ff <= '0;
         debug_drive_ff  <= '0;
         left_dir_ff     <= 1'b0;
         right_dir_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CTRL_MODE:    mode_ff         <= csr_data[1:0];
            CSR_PROP_GAIN:    gains_ff.prop   <= csr_data;
            CSR_INTEG_GAIN:   gains_ff.integ  <= csr_data;
            CSR_LEFT_TARGET:  left_target_ff  <= csr_data;
            CSR_RIGHT_TARGET: right_target_ff <= csr_data;
            CSR_DEBUG_DRIVE:  debug_drive_ff  <= csr_data[DEBUG_W-1:0];
            CSR_LEFT_DIR:     left_dir_ff     <= csr_data[0];
            CSR_RIGHT_DIR:    right_dir_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // a tick moves on when the result register is free or draining
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   // tick divider, held outside speed mode
   assign speed_tick = advance && (mode_ff == MODE_SPEED);
   assign pi_update  = speed_tick && (phase_ff == PHASE_LAST);
   always_comb begin
      phase_in = phase_ff;
      if (speed_tick) begin
         phase_in = pi_update ? '0 : phase_ff + PHASE_W'(1);
      end
   end

   dwpi_pi_loop #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_left_loop (
      .clock  (clock),
      .reset  (reset),
      .update (pi_update),
      .gains  (gains_ff),
      .target (left_target_ff),
      .meas   (in_left_ff),
      .drive  (left_pi)
   );

   dwpi_pi_loop #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_right_loop (
      .clock  (clock),
      .reset  (reset),
      .update (pi_update),
      .gains  (gains_ff),
      .target (right_target_ff),
      .meas   (in_right_ff),
      .drive  (right_pi)
   );

   // drive selection by mode, mode three acts as zero drive
   always_comb begin
      dbg_drv = clamp_drive(DRIVE_W'(debug_drive_ff), LIMIT);
      case (mode_ff)
         MODE_DEBUG: begin
            left_drv  = dbg_drv;
            right_drv = dbg_drv;
         end
         MODE_SPEED: begin
            left_drv  = left_pi;
            right_drv = right_pi;
         end
         default: begin
            left_drv  = '0;
            right_drv = '0;
         end
      endcase
   end

   dwpi_bridge_map u_right_map (
      .drive    (right_drv),
      .pos_on_a (right_dir_ff),
      .cmp      (right_cmp)
   );

   dwpi_bridge_map u_left_map (
      .drive    (left_drv),
      .pos_on_a (!left_dir_ff),
      .cmp      (left_cmp)
   );

   always_comb begin
      if (in_lock_ff) begin
         data_in = {BRAKE_LEVEL, BRAKE_LEVEL, BRAKE_LEVEL, BRAKE_LEVEL};
      end else begin
         data_in = {left_cmp.cmp_b, left_cmp.cmp_a, right_cmp.cmp_b, right_cmp.cmp_a};
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_left_ff  <= req_tdata[15:0];
         in_right_ff <= req_tdata[31:16];
         in_lock_ff  <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff  <= data_in;
         rsp_brake_ff <= in_lock_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_brake_ff;

endmodule
`default_nettype wire

>>> hdl/dwpi_checker.sv
// port-level checks of the drive's result words, bound to the top level
`default_nettype none
module dwpi_checker
   import dwpi_pkg::*;
#(
   parameter int DRIVE_LIMIT = 999
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   localparam logic [CMP_W:0] CMP_MAX =
      (DRIVE_LIMIT > 1023) ? 11'd1023 : (CMP_W+1)'(DRIVE_LIMIT);

   // braking forces every compare value to the brake level
   a_brake_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[9:0] == BRAKE_LEVEL) && (rsp_tdata[19:10] == BRAKE_LEVEL) &&
         (rsp_tdata[29:20] == BRAKE_LEVEL) && (rsp_tdata[39:30] == BRAKE_LEVEL))
      else $error("brake word without brake level");

   // outside braking, only one side of each bridge is driven
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         ((rsp_tdata[9:0] == '0) || (rsp_tdata[19:10] == '0)) &&
         ((rsp_tdata[29:20] == '0) || (rsp_tdata[39:30] == '0)))
      else $error("both channels of a bridge driven");

   // unbraked compare values stay within the drive limit
   a_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         ({1'b0, rsp_tdata[9:0]} <= CMP_MAX) && ({1'b0, rsp_tdata[19:10]} <= CMP_MAX) &&
         ({1'b0, rsp_tdata[29:20]} <= CMP_MAX) && ({1'b0, rsp_tdata[39:30]} <= CMP_MAX))
      else $error("compare value beyond drive limit");

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

endmodule

bind dual_wheel_pi_speed_hbridge_drive dwpi_checker #(
   .DRIVE_LIMIT (DRIVE_LIMIT)
) u_dwpi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

>>> tb/tb_top.sv
// testbench for the dual wheel pi speed drive: directed table plus random ticks, checked per word
`timescale 1ns / 1ps
module tb_top;
   import dwpi_pkg::*;

   // block parameters, kept at their defaults and passed in explicitly
   localparam int TICKS_PER_UPDATE = 2;
   localparam int DRIVE_MAX = 999;

   // clamps in Q.4 units: +-50 cm/s error, +-600 integral
   localparam longint ERR_CLAMP_Q4 = 800;
   localparam longint INTEG_CLAMP_Q4 = 9600;

   // mode three has no package name and behaves as zero drive
   localparam logic [1:0] MODE_ZERO_ALT = 2'd3;

   localparam int RANDOM_TICKS = 850;
   localparam int IDLE_PCT = 37;
   localparam int REPORT_MAX = 10;

   // one result word, field by field
   typedef struct packed {
      logic [CMP_W-1:0] right_a;
      logic [CMP_W-1:0] right_b;
      logic [CMP_W-1:0] left_a;
      logic [CMP_W-1:0] left_b;
      logic braking;
   } bridge_word_type;

   typedef enum logic {ROW_CSR, ROW_TICK} row_kind_type;

   // one row of the directed stimulus table
   typedef struct {
      row_kind_type kind;
      csr_index_type idx;
      logic [15:0] value;
      logic [15:0] left_speed;
      logic [15:0] right_speed;
      logic lock;
      bit pinned;
      bridge_word_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [31:0] req_tdata;   // left_speed, right_speed
   logic req_tuser;          // locked
   logic rsp_tvalid;
   logic rsp_tready;
   logic [39:0] rsp_tdata;   // right_cmp_a, right_cmp_b, left_cmp_a, left_cmp_b
   logic rsp_tuser;          // braking
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   dual_wheel_pi_speed_hbridge_drive #(
      .TICK_DIVIDE(TICKS_PER_UPDATE),
      .DRIVE_LIMIT(DRIVE_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow copy of the registers, reset values as the block documents
   logic [1:0] cfg_mode = MODE_SPEED;
   longint cfg_kp = 0;
   longint cfg_ki = 0;
   longint cfg_target [2] = '{0, 0};   // 0 left, 1 right
   longint cfg_debug = 0;
   bit cfg_left_dir = 0;
   bit cfg_right_dir = 0;

   // shadow copy of the controller state
   int tick_phase = 0;
   longint wheel_integ [2] = '{0, 0};
   longint wheel_drive [2] = '{0, 0};

   // expected result words in arrival order
   bridge_word_type pending_cmp [$];

   // directed rows may pin the expected word instead of taking the prediction
   bit pin_next = 0;
   bridge_word_type pin_word;

   bit idle_on = 1;
   int mismatches = 0;
   int words_checked = 0;
   int ticks_sent = 0;
   int locked_sent = 0;
   int csr_writes = 0;
   int pi_updates = 0;
   stim_row_type directed_rows [$];

   bridge_word_type accepted_word;
   bridge_word_type arrived_word;
   bridge_word_type oldest_word;

   function automatic longint clip(input longint x, input longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   // one pi loop: clamp the error, integrate with clamp, add the proportional part
   function automatic void run_pi(input int w, input longint meas);
      longint err;
      longint acc;
      longint sum;
      err = clip(cfg_target[w] - meas, ERR_CLAMP_Q4);
      // >>> on a signed longint floors, as the q.12 to q.4 truncation does
      acc = clip(wheel_integ[w] + ((cfg_ki * err) >>> 8), INTEG_CLAMP_Q4);
      wheel_integ[w] = acc;
      sum = acc + ((cfg_kp * err) >>> 8);
      // q.4 to integer toward zero, then the drive limit
      wheel_drive[w] = clip(sum / 16, DRIVE_MAX);
   endfunction

   // drive onto the two bridge channels; magnitude wraps to 10 bits
   function automatic void to_bridge(input longint d, input bit pos_on_a,
                                     output logic [CMP_W-1:0] a,
                                     output logic [CMP_W-1:0] b);
      logic [CMP_W-1:0] mag;
      bit on_a;
      mag = CMP_W'((d < 0) ? -d : d);
      on_a = (d >= 0) ? pos_on_a : !pos_on_a;
      a = on_a ? mag : '0;
      b = on_a ? '0 : mag;
   endfunction

   // advances the shadow state by one tick and returns the word it produces
   function automatic bridge_word_type next_bridge_cmp(input logic [15:0] left_speed,
                                                       input logic [15:0] right_speed,
                                                       input logic lock);
      bridge_word_type w;
      longint left_d;
      longint right_d;
      if (cfg_mode == MODE_SPEED) begin
         tick_phase++;
         if (tick_phase >= TICKS_PER_UPDATE) begin
            tick_phase = 0;
            pi_updates++;
            run_pi(0, longint'($signed(left_speed)));
            run_pi(1, longint'($signed(right_speed)));
         end
      end
      if (lock) begin
         w.right_a = BRAKE_LEVEL;
         w.right_b = BRAKE_LEVEL;
         w.left_a = BRAKE_LEVEL;
         w.left_b = BRAKE_LEVEL;
         w.braking = 1'b1;
         return w;
      end
      case (cfg_mode)
         MODE_DEBUG: begin
            left_d = clip(cfg_debug, DRIVE_MAX);
            right_d = left_d;
         end
         MODE_SPEED: begin
            left_d = wheel_drive[0];
            right_d = wheel_drive[1];
         end
         default: begin
            left_d = 0;
            right_d = 0;
         end
      endcase
      // right and left bridges are wired with opposite sense at polarity 0
      to_bridge(right_d, cfg_right_dir, w.right_a, w.right_b);
      to_bridge(left_d, !cfg_left_dir, w.left_a, w.left_b);
      w.braking = 1'b0;
      return w;
   endfunction

   function automatic void apply_csr(input csr_index_type idx, input logic [15:0] v);
      case (idx)
         CSR_CTRL_MODE: cfg_mode = v[1:0];
         CSR_PROP_GAIN: cfg_kp = longint'(v);
         CSR_INTEG_GAIN: cfg_ki = longint'(v);
         CSR_LEFT_TARGET: cfg_target[0] = longint'($signed(v));
         CSR_RIGHT_TARGET: cfg_target[1] = longint'($signed(v));
         CSR_DEBUG_DRIVE: cfg_debug = longint'($signed(v[DEBUG_W-1:0]));
         CSR_LEFT_DIR: cfg_left_dir = v[0];
         CSR_RIGHT_DIR: cfg_right_dir = v[0];
         default: ;
      endcase
   endfunction

   function automatic bridge_word_type cmp_word(input int ra, input int rb, input int la,
                                                input int lb, input bit brk);
      bridge_word_type w;
      w.right_a = CMP_W'(ra);
      w.right_b = CMP_W'(rb);
      w.left_a = CMP_W'(la);
      w.left_b = CMP_W'(lb);
      w.braking = brk;
      return w;
   endfunction

   function automatic void check_field(input string what, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_MAX) begin
            $display("mismatch on word %0d, %s: expected %0d, got %0d",
                     words_checked, what, want, got);
         end
      end
   endfunction

   // directed table builders
   function automatic void row_csr(input csr_index_type idx, input logic [15:0] v);
      stim_row_type r;
      r.kind = ROW_CSR;
      r.idx = idx;
      r.value = v;
      r.pinned = 0;
      directed_rows.push_back(r);
   endfunction

   function automatic void row_tick(input logic [15:0] ls, input logic [15:0] rs,
                                    input logic lock, input bit pinned,
                                    input bridge_word_type want);
      stim_row_type r;
      r.kind = ROW_TICK;
      r.idx = CSR_CTRL_MODE;
      r.left_speed = ls;
      r.right_speed = rs;
      r.lock = lock;
      r.pinned = pinned;
      r.want = want;
      directed_rows.push_back(r);
   endfunction

   function automatic logic [15:0] pick_gain();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 16'h0000;
      if (roll == 1) return 16'hFFFF;
      if (roll < 6) return 16'($urandom_range(511));
      return 16'($urandom_range(16'h2000));
   endfunction

   function automatic logic [15:0] pick_target();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 16'h7FFF;
      if (roll == 1) return 16'h8000;
      if (roll == 2) return 16'($urandom);
      return 16'(int'($urandom_range(8000)) - 4000);
   endfunction

   // mostly speeds near the target so the loops settle, with extremes and noise
   function automatic logic [15:0] pick_speed(input longint target);
      int roll;
      roll = $urandom_range(19);
      if (roll < 12) return 16'(target + longint'(int'($urandom_range(1800)) - 900));
      if (roll < 17) return 16'($urandom);
      if (roll == 17) return 16'h7FFF;
      if (roll == 18) return 16'h8000;
      return 16'h0000;
   endfunction

   // wait until every expected word is back and the pipe has drained
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_cmp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] v);
      wait_idle();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, v);
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // valid stays high after the word is taken so back to back words need no gap
   task automatic send_tick(input logic [15:0] ls, input logic [15:0] rs, input logic lock,
                            input bit pinned, input bridge_word_type want);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {rs, ls};
      req_tuser = lock;
      pin_next = pinned;
      pin_word = want;
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
      if (lock) locked_sent++;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver side stalls on its own schedule
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
      end
   end

   // accepted words are predicted and results checked at the same edge, push first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accepted_word = next_bridge_cmp(req_tdata[15:0], req_tdata[31:16], req_tuser);
            if (pin_next) accepted_word = pin_word;
            pending_cmp.push_back(accepted_word);
         end
         if (rsp_tvalid && rsp_tready) begin
            arrived_word.right_a = rsp_tdata[9:0];
            arrived_word.right_b = rsp_tdata[19:10];
            arrived_word.left_a = rsp_tdata[29:20];
            arrived_word.left_b = rsp_tdata[39:30];
            arrived_word.braking = rsp_tuser;
            if (pending_cmp.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("result word with nothing expected: %h braking %b",
                           rsp_tdata, rsp_tuser);
               end
            end else begin
               oldest_word = pending_cmp.pop_front();
               check_field("right_cmp_a", oldest_word.right_a, arrived_word.right_a);
               check_field("right_cmp_b", oldest_word.right_b, arrived_word.right_b);
               check_field("left_cmp_a", oldest_word.left_a, arrived_word.left_a);
               check_field("left_cmp_b", oldest_word.left_b, arrived_word.left_b);
               check_field("braking", oldest_word.braking, arrived_word.braking);
            end
            words_checked++;
         end
      end
   end

   // hard stop well past the slowest legal run
   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

   initial begin
      bridge_word_type zeros;
      bridge_word_type brake;
      bridge_word_type none;
      logic [1:0] mode;
      int random_ticks;
      int roll;
      int burst;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CTRL_MODE;
      csr_data = '0;

      zeros = cmp_word(0, 0, 0, 0, 0);
      brake = cmp_word(1000, 1000, 1000, 1000, 1);
      none = zeros;

      // after reset: speed mode, zero gains, so the first tick drives nothing
      row_tick(16'h0000, 16'h0000, 1'b0, 1, zeros);
      // lock with extreme speeds, also the first pi update
      row_tick(16'h7FFF, 16'h8000, 1'b1, 1, brake);
      // largest gains and opposite extreme targets saturate every clamp
      row_csr(CSR_PROP_GAIN, 16'hFFFF);
      row_csr(CSR_INTEG_GAIN, 16'hFFFF);
      row_csr(CSR_LEFT_TARGET, 16'h7FFF);
      row_csr(CSR_RIGHT_TARGET, 16'h8000);
      row_tick(16'h8000, 16'h7FFF, 1'b0, 0, none);
      row_tick(16'h8000, 16'h7FFF, 1'b0, 0, none);
      row_tick(16'h7FFF, 16'h8000, 1'b0, 0, none);
      row_tick(16'h7FFF, 16'h8000, 1'b0, 0, none);
      // locked ticks still move the loops
      row_tick(16'hFFFF, 16'h0001, 1'b1, 1, brake);
      row_tick(16'h0000, 16'hFFFF, 1'b1, 1, brake);
      row_csr(CSR_LEFT_DIR, 16'h0001);
      row_csr(CSR_RIGHT_DIR, 16'h0001);
      row_tick(16'h8000, 16'h7FFF, 1'b0, 0, none);
      row_tick(16'h8000, 16'h7FFF, 1'b0, 0, none);
      // debug drive at both extremes, clamped to the drive limit, polarity 1
      row_csr(CSR_CTRL_MODE, 16'(MODE_DEBUG));
      row_csr(CSR_DEBUG_DRIVE, 16'h07FF);
      row_tick(16'h0000, 16'h0000, 1'b0, 1, cmp_word(999, 0, 0, 999, 0));
      row_csr(CSR_DEBUG_DRIVE, 16'h0800);
      row_tick(16'h5555, 16'hAAAA, 1'b0, 1, cmp_word(0, 999, 999, 0, 0));
      // small debug drives at polarity 0; upper data bits are ignored
      row_csr(CSR_LEFT_DIR, 16'h0000);
      row_csr(CSR_RIGHT_DIR, 16'h0000);
      row_csr(CSR_DEBUG_DRIVE, 16'h0001);
      row_tick(16'h0000, 16'h0000, 1'b0, 1, cmp_word(0, 1, 1, 0, 0));
      row_csr(CSR_DEBUG_DRIVE, 16'hFFFF);
      row_tick(16'h0000, 16'h0000, 1'b0, 1, cmp_word(1, 0, 0, 1, 0));
      row_tick(16'h0000, 16'h0000, 1'b1, 1, brake);
      // zero drive mode and the unnamed mode three
      row_csr(CSR_CTRL_MODE, 16'(MODE_ZERO));
      row_tick(16'h1234, 16'h4321, 1'b0, 1, zeros);
      row_csr(CSR_CTRL_MODE, 16'(MODE_ZERO_ALT));
      row_tick(16'h8000, 16'h7FFF, 1'b0, 1, zeros);
      row_tick(16'h8000, 16'h7FFF, 1'b1, 1, brake);
      // back to speed control with moderate gains, speeds close to target
      row_csr(CSR_CTRL_MODE, 16'(MODE_SPEED));
      row_csr(CSR_PROP_GAIN, 16'h0180);
      row_csr(CSR_INTEG_GAIN, 16'h0040);
      row_csr(CSR_LEFT_TARGET, 16'h0100);
      row_csr(CSR_RIGHT_TARGET, 16'hFF00);
      row_tick(16'h00C0, 16'hFF40, 1'b0, 0, none);
      row_tick(16'h00C0, 16'hFF40, 1'b0, 0, none);
      row_tick(16'h0120, 16'hFEE0, 1'b0, 0, none);
      row_tick(16'h0120, 16'hFEE0, 1'b0, 0, none);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_csr(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            send_tick(directed_rows[i].left_speed, directed_rows[i].right_speed,
                      directed_rows[i].lock, directed_rows[i].pinned, directed_rows[i].want);
         end
      end
      pin_next = 0;

      // random phases: new settings while idle, then a burst of ticks
      random_ticks = 0;
      while (random_ticks < RANDOM_TICKS) begin
         // a long stretch with both sides running flat out
         idle_on = !(random_ticks >= 300 && random_ticks < 450);
         roll = $urandom_range(9);
         if (roll < 7) mode = MODE_SPEED;
         else if (roll == 7) mode = MODE_DEBUG;
         else if (roll == 8) mode = MODE_ZERO;
         else mode = MODE_ZERO_ALT;
         write_csr(CSR_CTRL_MODE, {14'($urandom), mode});
         if ($urandom_range(1)) write_csr(CSR_PROP_GAIN, pick_gain());
         if ($urandom_range(1)) write_csr(CSR_INTEG_GAIN, pick_gain());
         if ($urandom_range(2) == 0) write_csr(CSR_LEFT_TARGET, pick_target());
         if ($urandom_range(2) == 0) write_csr(CSR_RIGHT_TARGET, pick_target());
         if ($urandom_range(2) == 0) write_csr(CSR_DEBUG_DRIVE, 16'($urandom));
         if ($urandom_range(3) == 0) write_csr(CSR_LEFT_DIR, 16'($urandom));
         if ($urandom_range(3) == 0) write_csr(CSR_RIGHT_DIR, 16'($urandom));
         burst = $urandom_range(60, 15);
         repeat (burst) begin
            send_tick(pick_speed(cfg_target[0]), pick_speed(cfg_target[1]),
                      $urandom_range(9) == 0, 0, none);
            random_ticks++;
         end
      end

      // drain, then keep clocking the pipe so that any stray word would still show
      req_tvalid = 1'b0;
      idle_on = 0;
      while (pending_cmp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d ticks (%0d locked), %0d pi updates, %0d register writes",
               ticks_sent, locked_sent, pi_updates, csr_writes);
      $display("checked %0d result words, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0 && pending_cmp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
